// File: hdl/dpimb_pkg.sv
// ----------------------------------------------------------------------------
// dpimb_pkg: shared definitions for the differential PI motor balancer
// Field widths, datapath widths, digit size of the serial multiplier and
// configuration register indexes.
// ----------------------------------------------------------------------------
package dpimb_pkg;

  // Encoder count width of one wheel sample.
  localparam int COUNT_BITS = 12;

  // Configuration register widths.
  localparam int GAIN_W  = 16;
  localparam int BASE_W  = 8;
  localparam int LIMIT_W = 7;

  // Result widths.
  localparam int DUTY_W = 8;
  localparam int CORR_W = 16;

  // Datapath widths derived from the count width.
  localparam int DIFF_W   = COUNT_BITS + 1;
  localparam int ERR_W    = COUNT_BITS + 18;
  localparam int MCAND_W  = ERR_W + 1;
  localparam int PROD_W   = MCAND_W + GAIN_W;
  localparam int FRAC_W   = 8;
  localparam int TERM_W   = PROD_W - FRAC_W;
  localparam int SUM_W    = TERM_W + 2;
  localparam int DSUM_W   = BASE_W + FRAC_W + 2;

  // Serial multiplier: one digit of the gain per cycle.
  localparam int MUL_DIGIT_W = 4;
  localparam int MUL_STEPS   = GAIN_W / MUL_DIGIT_W;
  localparam int MUL_CNT_W   = $clog2(MUL_STEPS);

  // APB register map.
  localparam int PADDR_W = 5;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;

  localparam logic [REG_IDX_W-1:0] REG_KP_GAIN    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_KI_PERIOD  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_RPM_PULSE  = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_BASE_DUTY  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_CORR_LIMIT = 3'd4;

  // Reset values of the configuration registers.
  localparam logic [GAIN_W-1:0]  KP_RESET    = 16'd512;
  localparam logic [GAIN_W-1:0]  KI_RESET    = 16'd512;
  localparam logic [GAIN_W-1:0]  RPM_RESET   = 16'd7680;
  localparam logic [BASE_W-1:0]  BASE_RESET  = 8'd200;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd80;

endpackage

// File: hdl/dpimb_in_if.sv
// ----------------------------------------------------------------------------
// dpimb_in_if: input channel of the motor balancer
// Carries one pair of wheel pulse counts per item with valid/ready.
// ----------------------------------------------------------------------------
interface dpimb_in_if;

  logic                                      valid;
  logic                                      ready;
  logic signed [dpimb_pkg::COUNT_BITS-1:0]   pulses_a;
  logic signed [dpimb_pkg::COUNT_BITS-1:0]   pulses_b;

  modport source (output valid, output pulses_a, output pulses_b, input ready);
  modport sink   (input valid, input pulses_a, input pulses_b, output ready);

endinterface

// File: hdl/dpimb_out_if.sv
// ----------------------------------------------------------------------------
// dpimb_out_if: result channel of the motor balancer
// Carries both motor duties and the saturated correction with valid/ready.
// ----------------------------------------------------------------------------
interface dpimb_out_if;

  logic                                  valid;
  logic                                  ready;
  logic        [dpimb_pkg::DUTY_W-1:0]   duty_a;
  logic        [dpimb_pkg::DUTY_W-1:0]   duty_b;
  logic signed [dpimb_pkg::CORR_W-1:0]   correction;

  modport source (output valid, output duty_a, output duty_b, output correction,
                  input ready);
  modport sink   (input valid, input duty_a, input duty_b, input correction,
                  output ready);

endinterface

// File: hdl/dpimb_mul.sv
// ----------------------------------------------------------------------------
// dpimb_mul: digit-serial signed by unsigned multiplier
// Consumes the unsigned multiplier one digit per cycle, least significant
// first, and shifts the finished low product bits into a shift register.
// ----------------------------------------------------------------------------
module dpimb_mul (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [dpimb_pkg::MCAND_W-1:0]   mcand,
  input  logic        [dpimb_pkg::GAIN_W-1:0]    mplier,
  output logic                                   done,
  output logic signed [dpimb_pkg::PROD_W-1:0]    product
);

  localparam int PSUM_W = dpimb_pkg::MCAND_W + dpimb_pkg::MUL_DIGIT_W + 1;

  logic                                   busy_r;
  logic                                   done_r;
  logic [dpimb_pkg::MUL_CNT_W-1:0]        cnt_r;
  logic signed [dpimb_pkg::MCAND_W-1:0]   mc_r;
  logic [dpimb_pkg::GAIN_W-1:0]           mp_r;
  logic signed [dpimb_pkg::MCAND_W-1:0]   hi_r;
  logic [dpimb_pkg::GAIN_W-1:0]           lo_r;

  logic signed [dpimb_pkg::MUL_DIGIT_W:0] digit;
  logic signed [PSUM_W-1:0]               psum;

  assign digit = signed'({1'b0, mp_r[dpimb_pkg::MUL_DIGIT_W-1:0]});
  assign psum  = PSUM_W'(hi_r) + PSUM_W'(mc_r) * PSUM_W'(digit);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        mc_r   <= mcand;
        mp_r   <= mplier;
        hi_r   <= '0;
      end else if (busy_r) begin
        hi_r  <= psum[dpimb_pkg::MCAND_W+dpimb_pkg::MUL_DIGIT_W-1:dpimb_pkg::MUL_DIGIT_W];
        lo_r  <= {psum[dpimb_pkg::MUL_DIGIT_W-1:0],
                  lo_r[dpimb_pkg::GAIN_W-1:dpimb_pkg::MUL_DIGIT_W]};
        mp_r  <= mp_r >> dpimb_pkg::MUL_DIGIT_W;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == dpimb_pkg::MUL_CNT_W'(dpimb_pkg::MUL_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done    = done_r;
  assign product = signed'({hi_r, lo_r});

endmodule

// File: hdl/differential_pi_motor_balance.sv
// ----------------------------------------------------------------------------
// differential_pi_motor_balance: velocity-form PI wheel speed balancer
// Turns the pulse count difference of two wheels into a saturated PI
// correction and two clamped PWM duties.
// ----------------------------------------------------------------------------
//
//   Port group  | Direction | Handshake        | Content
//   ------------+-----------+------------------+---------------------------------
//   in_item     | sink      | valid / ready    | pulses_a, pulses_b
//   out_item    | source    | valid / ready    | duty_a, duty_b, correction
//   cfg_*       | slave     | APB, pready high | gains, scale, base duty, limit
//
// The block accepts a new item only when idle, after the previous item has
// written its result to the output register. The work is done mostly by the
// shared multiplier, which forms three products in turn (error scaling,
// proportional term, integral term), one 4-bit digit of the 16-bit gain per
// cycle, followed by a clamp step and a duty calculation step.
// Reset is synchronous and active low; it restores the default gains and
// clears the previous error and the accumulated correction.
// A finished result that is not taken waits in the output register; the next
// item is still accepted and computed, and only its final step waits for the
// output register to free up.
// ----------------------------------------------------------------------------
module differential_pi_motor_balance (
  input  logic                                 clk,
  input  logic                                 rst_n,
  dpimb_in_if.sink                             in_item,
  dpimb_out_if.source                          out_item,
  input  logic                                 cfg_psel,
  input  logic                                 cfg_penable,
  input  logic                                 cfg_pwrite,
  input  logic [dpimb_pkg::PADDR_W-1:0]        cfg_paddr,
  input  logic [dpimb_pkg::PDATA_W-1:0]        cfg_pwdata,
  output logic [dpimb_pkg::PDATA_W-1:0]        cfg_prdata,
  output logic                                 cfg_pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ERR,
    S_KP,
    S_KI,
    S_CLAMP,
    S_DUTY
  } state_t;

  // Truncates a Q.8 duty to whole units and clamps it to the duty range.
  function automatic logic [dpimb_pkg::DUTY_W-1:0] duty_of(
    input logic signed [dpimb_pkg::DSUM_W-1:0] scaled
  );
    logic [dpimb_pkg::DUTY_W-1:0] res;
    if (scaled[dpimb_pkg::DSUM_W-1]) begin
      res = '0;
    end else if (scaled[dpimb_pkg::DSUM_W-2]) begin
      res = '1;
    end else begin
      res = scaled[dpimb_pkg::FRAC_W+dpimb_pkg::DUTY_W-1:dpimb_pkg::FRAC_W];
    end
    return res;
  endfunction

  // Configuration registers.
  logic [dpimb_pkg::GAIN_W-1:0]   kp_r;
  logic [dpimb_pkg::GAIN_W-1:0]   ki_r;
  logic [dpimb_pkg::GAIN_W-1:0]   rpm_r;
  logic [dpimb_pkg::BASE_W-1:0]   base_r;
  logic [dpimb_pkg::LIMIT_W-1:0]  limit_r;

  logic [dpimb_pkg::REG_IDX_W-1:0] reg_idx;
  logic                            cfg_write;

  assign reg_idx   = cfg_paddr[dpimb_pkg::PADDR_W-1:2];
  assign cfg_write = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r    <= dpimb_pkg::KP_RESET;
      ki_r    <= dpimb_pkg::KI_RESET;
      rpm_r   <= dpimb_pkg::RPM_RESET;
      base_r  <= dpimb_pkg::BASE_RESET;
      limit_r <= dpimb_pkg::LIMIT_RESET;
    end else if (cfg_write) begin
      case (reg_idx)
        dpimb_pkg::REG_KP_GAIN:    kp_r    <= cfg_pwdata[dpimb_pkg::GAIN_W-1:0];
        dpimb_pkg::REG_KI_PERIOD:  ki_r    <= cfg_pwdata[dpimb_pkg::GAIN_W-1:0];
        dpimb_pkg::REG_RPM_PULSE:  rpm_r   <= cfg_pwdata[dpimb_pkg::GAIN_W-1:0];
        dpimb_pkg::REG_BASE_DUTY:  base_r  <= cfg_pwdata[dpimb_pkg::BASE_W-1:0];
        dpimb_pkg::REG_CORR_LIMIT: limit_r <= cfg_pwdata[dpimb_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      dpimb_pkg::REG_KP_GAIN:    cfg_prdata = dpimb_pkg::PDATA_W'(kp_r);
      dpimb_pkg::REG_KI_PERIOD:  cfg_prdata = dpimb_pkg::PDATA_W'(ki_r);
      dpimb_pkg::REG_RPM_PULSE:  cfg_prdata = dpimb_pkg::PDATA_W'(rpm_r);
      dpimb_pkg::REG_BASE_DUTY:  cfg_prdata = dpimb_pkg::PDATA_W'(base_r);
      dpimb_pkg::REG_CORR_LIMIT: cfg_prdata = dpimb_pkg::PDATA_W'(limit_r);
      default:                   cfg_prdata = '0;
    endcase
  end

  // Controller state and datapath registers.
  state_t                                state_r, state_nxt;
  logic signed [dpimb_pkg::ERR_W-1:0]    err_r, err_nxt;
  logic signed [dpimb_pkg::ERR_W-1:0]    prev_err_r, prev_err_nxt;
  logic signed [dpimb_pkg::CORR_W-1:0]   acc_r, acc_nxt;
  logic signed [dpimb_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                                  out_valid_r, out_valid_nxt;
  logic [dpimb_pkg::DUTY_W-1:0]          duty_a_r, duty_a_nxt;
  logic [dpimb_pkg::DUTY_W-1:0]          duty_b_r, duty_b_nxt;
  logic signed [dpimb_pkg::CORR_W-1:0]   corr_out_r, corr_out_nxt;

  // Shared multiplier.
  logic                                  mul_start;
  logic signed [dpimb_pkg::MCAND_W-1:0]  mul_mcand;
  logic [dpimb_pkg::GAIN_W-1:0]          mul_mplier;
  logic                                  mul_done;
  logic signed [dpimb_pkg::PROD_W-1:0]   mul_product;

  dpimb_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .mcand   (mul_mcand),
    .mplier  (mul_mplier),
    .done    (mul_done),
    .product (mul_product)
  );

  logic                                  in_fire;
  logic signed [dpimb_pkg::DIFF_W-1:0]   diff_w;
  logic signed [dpimb_pkg::ERR_W-1:0]    err_w;
  logic signed [dpimb_pkg::MCAND_W-1:0]  delta_w;
  logic signed [dpimb_pkg::TERM_W-1:0]   term_w;
  logic signed [dpimb_pkg::SUM_W-1:0]    lim_w;
  logic signed [dpimb_pkg::CORR_W-1:0]   corr_w;
  logic signed [dpimb_pkg::DSUM_W-1:0]   base_w;
  logic signed [dpimb_pkg::DSUM_W-1:0]   corr_ext_w;

  assign in_item.ready = (state_r == S_IDLE);
  assign in_fire       = in_item.valid & in_item.ready;

  assign diff_w = dpimb_pkg::DIFF_W'(in_item.pulses_a) - dpimb_pkg::DIFF_W'(in_item.pulses_b);

  // The error product fits within the error width, so the low bits are the value.
  assign err_w   = signed'(mul_product[dpimb_pkg::ERR_W-1:0]);
  assign delta_w = dpimb_pkg::MCAND_W'(err_w) - dpimb_pkg::MCAND_W'(prev_err_r);

  // Dropping the eight fraction bits of a two's complement product is a floor shift.
  assign term_w = signed'(mul_product[dpimb_pkg::PROD_W-1:dpimb_pkg::FRAC_W]);

  assign lim_w = signed'(dpimb_pkg::SUM_W'({limit_r, {dpimb_pkg::FRAC_W{1'b0}}}));

  always_comb begin
    if (sum_r > lim_w) begin
      corr_w = dpimb_pkg::CORR_W'(lim_w);
    end else if (sum_r < -lim_w) begin
      corr_w = dpimb_pkg::CORR_W'(-lim_w);
    end else begin
      corr_w = dpimb_pkg::CORR_W'(sum_r);
    end
  end

  assign base_w     = signed'(dpimb_pkg::DSUM_W'({base_r, {dpimb_pkg::FRAC_W{1'b0}}}));
  assign corr_ext_w = dpimb_pkg::DSUM_W'(acc_r);

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    prev_err_nxt  = prev_err_r;
    acc_nxt       = acc_r;
    sum_nxt       = sum_r;
    out_valid_nxt = out_valid_r;
    duty_a_nxt    = duty_a_r;
    duty_b_nxt    = duty_b_r;
    corr_out_nxt  = corr_out_r;
    mul_start     = 1'b0;
    mul_mcand     = dpimb_pkg::MCAND_W'(diff_w);
    mul_mplier    = rpm_r;

    if (out_valid_r && out_item.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        // Scale the pulse difference into a Q.8 speed error.
        if (in_fire) begin
          mul_start = 1'b1;
          state_nxt = S_ERR;
        end
      end
      S_ERR: begin
        // Proportional term works on the change of the error.
        if (mul_done) begin
          err_nxt    = err_w;
          mul_start  = 1'b1;
          mul_mcand  = delta_w;
          mul_mplier = kp_r;
          state_nxt  = S_KP;
        end
      end
      S_KP: begin
        if (mul_done) begin
          sum_nxt    = dpimb_pkg::SUM_W'(acc_r) + dpimb_pkg::SUM_W'(term_w);
          mul_start  = 1'b1;
          mul_mcand  = dpimb_pkg::MCAND_W'(err_r);
          mul_mplier = ki_r;
          state_nxt  = S_KI;
        end
      end
      S_KI: begin
        if (mul_done) begin
          sum_nxt   = sum_r + dpimb_pkg::SUM_W'(term_w);
          state_nxt = S_CLAMP;
        end
      end
      S_CLAMP: begin
        acc_nxt      = corr_w;
        prev_err_nxt = err_r;
        state_nxt    = S_DUTY;
      end
      S_DUTY: begin
        // The saturated correction now sits in the accumulator.
        if (!out_valid_r || out_item.ready) begin
          duty_a_nxt    = duty_of(base_w - corr_ext_w);
          duty_b_nxt    = duty_of(base_w + corr_ext_w);
          corr_out_nxt  = acc_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_err_r  <= '0;
      acc_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_err_r  <= prev_err_nxt;
      acc_r       <= acc_nxt;
    end
    err_r      <= err_nxt;
    sum_r      <= sum_nxt;
    duty_a_r   <= duty_a_nxt;
    duty_b_r   <= duty_b_nxt;
    corr_out_r <= corr_out_nxt;
  end

  assign out_item.valid      = out_valid_r;
  assign out_item.duty_a     = duty_a_r;
  assign out_item.duty_b     = duty_b_r;
  assign out_item.correction = corr_out_r;

endmodule
